[hw/rtl/cfer_pkg.sv]
// Shared types and constants for the checksum frame echo responder.
// No dependencies; the top level, cfer_front and cfer_back import this package.
package cfer_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int PAYLOAD_MAX = FRAME_BYTES - 4;
   localparam int IDX_W       = $clog2(PAYLOAD_MAX);
   localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int RAM_DEPTH   = 2 ** ADDR_W;

   localparam logic [7:0] REQUEST_HEADER_RESET = 8'hA8;
   localparam logic [7:0] REPLY_HEADER_RESET   = 8'hF8;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_HEADER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_HEADER   = 1'b1;

   // Reply order from the front end to the back end.
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] length;
   } cmd_type;

   // Payload store write port driven by the front end.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   // One reply byte waiting at the output.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       reply_last;
   } rsp_entry_type;

endpackage

[hw/rtl/checksum_frame_echo_responder.sv]
// Checksum frame echo responder: parses length-prefixed request frames and echoes good ones.
// A good checksum byte fills the order slot, then the back end queues the header once it has room.
// Throughput: one byte per cycle, but a checksum byte waits until the previous reply is queued;
// a reply has L+4 bytes, and each payload byte takes an address state, then an output state.
// Reset (synchronous): headers return to 0xA8 / 0xF8, the parser hunts, all queues empty.
// Depends on cfer_pkg, cfer_ram, cfer_front and cfer_back.
module checksum_frame_echo_responder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_reply_last,
   input  logic                             csr_write_enable,
   input  logic [cfer_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_write_data
);
   import cfer_pkg::*;

   // Configuration registers.
   logic [7:0]    req_hdr_ff;
   logic [7:0]    rsp_hdr_ff;

   // One-entry order slot between front and back. The front end writes one
   // bank of the payload store while the back end reads the other; the slot
   // stays full until the back end has queued the whole reply, so a bank is
   // never overwritten while a reply still reads it.
   logic          cmd_valid_ff;
   cmd_type       cmd_ff;

   logic          cmd_push;
   cmd_type       cmd_front;
   logic          cmd_done;
   ram_wr_type    ram_wr;
   logic          rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]    rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_hdr_ff <= REQUEST_HEADER_RESET;
         rsp_hdr_ff <= REPLY_HEADER_RESET;
         cmd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_REQUEST_HEADER: req_hdr_ff <= csr_write_data;
               CSR_REPLY_HEADER:   rsp_hdr_ff <= csr_write_data;
               default:            ;
            endcase
         end
         // Set on an accepted good frame, clear once the reply is fully queued.
         if (cmd_push) begin
            cmd_valid_ff <= 1'b1;
         end else if (cmd_done) begin
            cmd_valid_ff <= 1'b0;
         end
      end
      if (cmd_push) begin
         cmd_ff <= cmd_front;
      end
   end

   cfer_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_rx_byte    (req_rx_byte),
      .req_full       (req_full),
      .request_header (req_hdr_ff),
      .cmd_busy       (cmd_valid_ff),
      .cmd_push       (cmd_push),
      .cmd            (cmd_front),
      .ram_wr         (ram_wr)
   );

   // Two banks of payload, selected by the top address bit.
   cfer_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfer_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid_ff),
      .cmd            (cmd_ff),
      .reply_header   (rsp_hdr_ff),
      .cmd_done       (cmd_done),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_reply_last (rsp_reply_last)
   );

endmodule

[hw/rtl/cfer_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfer_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cfer_front.sv]
// Front end: parses request frames byte by byte and fills the payload store.
// Depends on cfer_pkg.
module cfer_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_rx_byte,
   output logic                req_full,
   input  logic [7:0]          request_header,
   input  logic                cmd_busy,
   output logic                cmd_push,
   output cfer_pkg::cmd_type   cmd,
   output cfer_pkg::ram_wr_type ram_wr
);
   import cfer_pkg::*;

   typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_DATA, PH_SUM} phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] length_ff, length_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [7:0]       sum_ff, sum_in;
   logic             bank_ff, bank_in;
   logic             accept;
   logic [CNT_W-1:0] seen_next;

   // Hold the checksum byte while the previous reply still owns the order slot.
   assign req_full  = (phase_ff == PH_SUM) && cmd_busy;
   assign accept    = req_push && !req_full;
   assign seen_next = seen_ff + CNT_W'(1);

   always_comb begin
      phase_in = phase_ff;
      length_in = length_ff;
      seen_in = seen_ff;
      sum_in = sum_ff;
      bank_in = bank_ff;
      cmd_push = 1'b0;
      ram_wr.en = 1'b0;
      ram_wr.addr = {bank_ff, seen_ff[IDX_W-1:0]};
      ram_wr.data = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == request_header) begin
                  sum_in = req_rx_byte;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (req_rx_byte > 8'(PAYLOAD_MAX)) begin
                  phase_in = PH_HUNT;
               end else begin
                  length_in = CNT_W'(req_rx_byte);
                  seen_in = '0;
                  sum_in = sum_ff + req_rx_byte;
                  phase_in = (req_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
               end
            end
            PH_DATA: begin
               ram_wr.en = 1'b1;
               sum_in = sum_ff + req_rx_byte;
               seen_in = seen_next;
               if (seen_next >= length_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (req_rx_byte == 8'(8'd0 - sum_ff)) begin
                  cmd_push = 1'b1;
                  bank_in = !bank_ff;
               end
               phase_in = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   assign cmd.bank   = bank_ff;
   assign cmd.length = length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         length_ff <= '0;
         seen_ff <= '0;
         sum_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         length_ff <= length_in;
         seen_ff <= seen_in;
         sum_ff <= sum_in;
         bank_ff <= bank_in;
      end
   end

endmodule

[hw/rtl/cfer_back.sv]
// Back end: streams one reply frame per order out of the payload store.
// Depends on cfer_pkg.
module cfer_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  cfer_pkg::cmd_type         cmd,
   input  logic [7:0]                reply_header,
   output logic                      cmd_done,
   output logic                      rd_en,
   output logic [cfer_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                rd_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_reply_last
);
   import cfer_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE, B_HDR, B_LEN, B_ADDR, B_DATA, B_ZERO, B_SUM
   } bstate_type;

   bstate_type       state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       len1;
   logic [CNT_W-1:0] idx_next;

   rsp_entry_type    entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop, fifo_full;
   rsp_entry_type    push_entry;

   assign fifo_full = (count_ff == 2'd2);
   assign pop       = rsp_pop && (count_ff != 2'd0);
   assign len1      = 8'(len_ff) + 8'd1;
   assign idx_next  = idx_ff + CNT_W'(1);
   assign rd_addr   = {bank_ff, idx_ff[IDX_W-1:0]};

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      push = 1'b0;
      push_entry.tx_byte = 8'd0;
      push_entry.reply_last = 1'b0;
      rd_en = 1'b0;
      cmd_done = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               bank_in = cmd.bank;
               len_in = cmd.length;
               idx_in = '0;
               state_in = B_HDR;
            end
         end
         B_HDR: begin
            if (!fifo_full) begin
               push = 1'b1;
               push_entry.tx_byte = reply_header;
               sum_in = reply_header;
               state_in = B_LEN;
            end
         end
         B_LEN: begin
            if (!fifo_full) begin
               push = 1'b1;
               push_entry.tx_byte = len1;
               sum_in = sum_ff + len1;
               state_in = (len_ff == '0) ? B_ZERO : B_ADDR;
            end
         end
         B_ADDR: begin
            rd_en = 1'b1;
            state_in = B_DATA;
         end
         B_DATA: begin
            if (!fifo_full) begin
               push = 1'b1;
               push_entry.tx_byte = rd_data;
               sum_in = sum_ff + rd_data;
               idx_in = idx_next;
               state_in = (idx_next == len_ff) ? B_ZERO : B_ADDR;
            end
         end
         B_ZERO: begin
            if (!fifo_full) begin
               push = 1'b1;
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            if (!fifo_full) begin
               push = 1'b1;
               push_entry.tx_byte = 8'd0 - sum_ff;
               push_entry.reply_last = 1'b1;
               cmd_done = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      bank_ff <= bank_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp_empty      = (count_ff == 2'd0);
   assign rsp_tx_byte    = entry_ff[rd_ptr_ff].tx_byte;
   assign rsp_reply_last = entry_ff[rd_ptr_ff].reply_last;

endmodule
